[rtl/rsd_pkg.sv]
package rsd_pkg;

  localparam int unsigned Lanes = 4;
  localparam int unsigned LaneW = $clog2(Lanes);

  typedef struct packed {
    logic [31:0] wall_sample;
    logic [31:0] cpu_sample;
    logic [31:0] user_sample;
    logic [31:0] system_sample;
  } in_word_t;

  typedef struct packed {
    logic [31:0] wall_deviation;
    logic [31:0] cpu_deviation;
    logic [31:0] user_deviation;
    logic [31:0] system_deviation;
    logic [31:0] samples_seen;
    logic        overflow_flag;
  } out_word_t;

  // One job handed from the front to the back: updated sums, count and saturation flag.
  typedef struct packed {
    logic [Lanes-1:0][63:0] sums;
    logic [31:0]            count;
    logic                   sat;
  } job_t;

  typedef enum logic [1:0] {
    CfgMeanWall   = 2'd0,
    CfgMeanCpu    = 2'd1,
    CfgMeanUser   = 2'd2,
    CfgMeanSystem = 2'd3
  } cfg_idx_e;

endpackage

[rtl/running_std_deviation.sv]
// Channel   Direction  Handshake             Word
// in        input      in_valid_i/in_stall_o  four 32-bit samples
// out       output     out_valid_o/out_stall_i four deviations, count, flag
// cfg       input      cfg_valid_i/cfg_ready_o index and 32-bit mean
// The front takes a word and accumulates one lane a cycle.
// The back works the lanes in turn on one shared bit-serial divide and
// square root, taking no new job until its word is out; this sets the rate.
// A two-entry queue parts front and back; the result sits in an output register.
// Reset clears sums, count, flag and means; no clearing pass is needed.
module running_std_deviation (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rsd_pkg::in_word_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rsd_pkg::out_word_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import rsd_pkg::*;

  job_t f_job, b_job;
  logic f_valid, f_ready, b_valid, b_ready;

  rsd_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .job_valid_o(f_valid), .job_ready_i(f_ready), .job_o(f_job)
  );

  rsd_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_data_i(f_job),
    .rd_valid_o(b_valid), .rd_ready_i(b_ready), .rd_data_o(b_job)
  );

  rsd_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(b_valid), .job_ready_o(b_ready), .job_i(b_job),
    .out_valid_o, .out_stall_i, .out_data_o
  );

endmodule

[rtl/rsd_front.sv]
module rsd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  rsd_pkg::in_word_t in_data_i,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [31:0]      cfg_data_i,
  output logic             job_valid_o,
  input  logic             job_ready_i,
  output rsd_pkg::job_t    job_o
);
  import rsd_pkg::*;

  typedef enum logic [2:0] {
    FIdle = 3'b001,
    FLane = 3'b010,
    FPush = 3'b100
  } fstate_e;

  fstate_e            state_q, state_d;
  logic [31:0]        mean_q [Lanes];
  logic [Lanes-1:0][63:0] sums_q;
  logic [31:0]        count_q;
  logic               sat_q;
  logic [LaneW-1:0]   lane_q;
  logic [Lanes-1:0][31:0] samp_q;
  logic [31:0]        diff;
  logic [63:0]        sq;
  logic [64:0]        add;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != FIdle);
  assign job_valid_o = (state_q == FPush);
  assign job_o.sums  = sums_q;
  assign job_o.count = count_q;
  assign job_o.sat   = sat_q;

  // Absolute difference and square for the lane in turn.
  always_comb begin
    diff = (samp_q[lane_q] >= mean_q[lane_q]) ? samp_q[lane_q] - mean_q[lane_q]
                                               : mean_q[lane_q] - samp_q[lane_q];
    sq   = diff * diff;
    add  = {1'b0, sums_q[lane_q]} + {1'b0, sq};
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FIdle: if (in_valid_i) state_d = FLane;
      FLane: if (lane_q == LaneW'(Lanes - 1)) state_d = FPush;
      FPush: if (job_ready_i) state_d = FIdle;
      default: state_d = FIdle;
    endcase
  end

  // Mean registers take writes at any time.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Lanes; k++) mean_q[k] <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgMeanWall:   mean_q[0] <= cfg_data_i;
        CfgMeanCpu:    mean_q[1] <= cfg_data_i;
        CfgMeanUser:   mean_q[2] <= cfg_data_i;
        CfgMeanSystem: mean_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Accumulation: one lane a cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FIdle;
      sums_q  <= '0;
      count_q <= '0;
      sat_q   <= 1'b0;
      lane_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == FIdle && in_valid_i) begin
        lane_q <= '0;
        if (count_q == '1) sat_q <= 1'b1;
        else count_q <= count_q + 32'd1;
      end else if (state_q == FLane) begin
        lane_q <= lane_q + LaneW'(1);
        if (add[64]) begin
          sums_q[lane_q] <= '1;
          sat_q          <= 1'b1;
        end else begin
          sums_q[lane_q] <= add[63:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == FIdle && in_valid_i) begin
      samp_q <= {in_data_i.system_sample, in_data_i.user_sample,
                 in_data_i.cpu_sample, in_data_i.wall_sample};
    end
  end

endmodule

[rtl/rsd_queue.sv]
module rsd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  rsd_pkg::job_t wr_data_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output rsd_pkg::job_t rd_data_o
);
  import rsd_pkg::*;

  // Two-entry queue of jobs.
  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

endmodule

[rtl/rsd_back.sv]
module rsd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  output logic               job_ready_o,
  input  rsd_pkg::job_t      job_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rsd_pkg::out_word_t out_data_o
);
  import rsd_pkg::*;

  typedef enum logic [3:0] {
    BIdle = 4'b0001,
    BDiv  = 4'b0010,
    BSqrt = 4'b0100,
    BOut  = 4'b1000
  } bstate_e;

  bstate_e              state_q;
  job_t                 job_q;
  logic [LaneW-1:0]     lane_q;
  logic [6:0]           step_q;
  logic [63:0]          quo_q;
  logic [32:0]          rem_q;
  logic [63:0]          rad_q;
  logic [31:0]          root_q;
  logic [33:0]          srem_q;
  logic [Lanes-1:0][31:0] dev_q;
  logic                 out_valid_q;
  logic [32:0]          rem_sh;
  logic [33:0]          srem_sh;
  logic [33:0]          trial;

  // One quotient bit or one root bit per cycle.
  always_comb begin
    rem_sh  = {rem_q[31:0], quo_q[63]};
    srem_sh = {srem_q[31:0], rad_q[63:62]};
    trial   = {root_q, 2'b01};
  end

  assign job_ready_o = (state_q == BIdle);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BIdle;
      out_valid_q <= 1'b0;
      lane_q      <= '0;
      step_q      <= '0;
    end else begin
      // A new word is loaded when the output register is free or being taken.
      if (state_q == BOut && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        BIdle: if (job_valid_i) begin
          state_q <= BDiv;
          lane_q  <= '0;
          step_q  <= '0;
        end
        BDiv: begin
          if (step_q == 7'd63) begin
            step_q  <= '0;
            state_q <= BSqrt;
          end else begin
            step_q <= step_q + 7'd1;
          end
        end
        BSqrt: begin
          if (step_q == 7'd31) begin
            step_q <= '0;
            if (lane_q == LaneW'(Lanes - 1)) state_q <= BOut;
            else begin
              lane_q  <= lane_q + LaneW'(1);
              state_q <= BDiv;
            end
          end else begin
            step_q <= step_q + 7'd1;
          end
        end
        BOut: if (!out_valid_q || !out_stall_i) begin
          state_q <= BIdle;
        end
        default: state_q <= BIdle;
      endcase
    end
  end

  // Restoring divide then restoring square root, shared over the lanes.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      BIdle: if (job_valid_i) begin
        job_q <= job_i;
        quo_q <= job_i.sums[0];
        rem_q <= '0;
      end
      BDiv: begin
        if (rem_sh >= {1'b0, job_q.count}) begin
          rem_q <= rem_sh - {1'b0, job_q.count};
          quo_q <= {quo_q[62:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          quo_q <= {quo_q[62:0], 1'b0};
        end
        if (step_q == 7'd63) begin
          rad_q  <= {quo_q[62:0], rem_sh >= {1'b0, job_q.count}};
          root_q <= '0;
          srem_q <= '0;
        end
      end
      BSqrt: begin
        rad_q <= {rad_q[61:0], 2'b00};
        if (srem_sh >= trial) begin
          srem_q <= srem_sh - trial;
          root_q <= {root_q[30:0], 1'b1};
        end else begin
          srem_q <= srem_sh;
          root_q <= {root_q[30:0], 1'b0};
        end
        if (step_q == 7'd31) begin
          dev_q[lane_q] <= {root_q[30:0], srem_sh >= trial};
          if (lane_q != LaneW'(Lanes - 1)) begin
            quo_q <= job_q.sums[lane_q + LaneW'(1)];
            rem_q <= '0;
          end
        end
      end
      BOut: if (!out_valid_q || !out_stall_i) begin
        out_data_o.wall_deviation   <= dev_q[0];
        out_data_o.cpu_deviation    <= dev_q[1];
        out_data_o.user_deviation   <= dev_q[2];
        out_data_o.system_deviation <= dev_q[3];
        out_data_o.samples_seen     <= job_q.count;
        out_data_o.overflow_flag    <= job_q.sat;
      end
      default: ;
    endcase
  end

endmodule

[rtl/rsd_checker.sv]
module rsd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input rsd_pkg::out_word_t out_data_o
);
  import rsd_pkg::*;

  // A stalled result word holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed under stall");

  // The count never reports zero.
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.samples_seen != 32'd0)
    else $error("zero count");

  // The overflow flag is sticky across results.
  a_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_data_o.overflow_flag
      |=> !out_valid_o || out_data_o.overflow_flag)
    else $error("flag dropped");

  // Right after an accept the front is busy.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("front took two words back to back");

endmodule

bind running_std_deviation rsd_checker u_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i, .out_data_o
);
